[rtl/string_key_merge_sorter_macros.svh]
// Assertion macros for the string key merge sorter RTL.
`ifndef STRING_KEY_MERGE_SORTER_MACROS_SVH
`define STRING_KEY_MERGE_SORTER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication check, disabled while reset is asserted.
`define SKMS_ASSERT_IMP(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("skms: same-cycle check failed");
// Next-cycle implication check, disabled while reset is asserted.
`define SKMS_ASSERT_NXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("skms: next-cycle check failed");
`else
`define SKMS_ASSERT_IMP(name, ck, rn, ante, cons)
`define SKMS_ASSERT_NXT(name, ck, rn, ante, cons)
`endif
`endif

[rtl/skms_pkg.sv]
// Types, constants and controller/datapath interface structs for the key merge sorter.
package skms_pkg;

	localparam int MAX_KEYS  = 64;
	localparam int MAX_CHARS = 8;
	localparam int KEY_BITS  = 64;
	localparam int KEY_BYTES = KEY_BITS / 8;
	localparam int LEN_W     = 4;
	localparam int ENTRY_W   = KEY_BITS + LEN_W;
	localparam int TDATA_W   = ((ENTRY_W + 7) / 8) * 8;
	localparam int IDX_W     = $clog2(MAX_KEYS);
	localparam int CNT_W     = IDX_W + 1;
	localparam int LO_W      = CNT_W + 1;
	localparam int MEM_AW    = IDX_W + 1;
	localparam int MEM_DEPTH = 2 ** MEM_AW;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [LO_W-1:0]  lo_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RUN,
		ST_MRD,
		ST_MWR,
		ST_ORD,
		ST_OWAIT
	} state_t;

	typedef struct packed {
		logic load_wr;
		logic merge_wr;
		logic dst_bank;
		idx_t wr_addr;
		logic take_j;
		logic rd_en;
		logic src_bank;
		idx_t rd_addr_a;
		idx_t rd_addr_b;
	} dp_cmd_t;

	typedef struct packed {
		logic after;
	} dp_stat_t;

endpackage

[rtl/skms_datapath.sv]
// Key store memory, input conditioning, key compare and read registers.
module skms_datapath (
	input  logic                           clk,
	input  logic [skms_pkg::KEY_BITS-1:0]  in_chars,
	input  logic [skms_pkg::LEN_W-1:0]     in_len,
	input  skms_pkg::dp_cmd_t              cmd,
	output skms_pkg::dp_stat_t             stat,
	output logic [skms_pkg::KEY_BITS-1:0]  out_chars,
	output logic [skms_pkg::LEN_W-1:0]     out_len
);
	import skms_pkg::*;

	logic [ENTRY_W-1:0]  mem_q [0:MEM_DEPTH-1];
	logic [ENTRY_W-1:0]  rd_a_q;
	logic [ENTRY_W-1:0]  rd_b_q;
	logic [LEN_W-1:0]    len_sat;
	logic [KEY_BITS-1:0] key_masked;
	logic [ENTRY_W-1:0]  wr_data;
	logic                wr_en;
	logic                wr_bank;
	logic [LEN_W-1:0]    len_a;
	logic [LEN_W-1:0]    len_b;

	// Saturate the length and clear bytes past it
	always_comb begin
		len_sat = (in_len > LEN_W'(MAX_CHARS)) ? LEN_W'(MAX_CHARS) : in_len;
		for (int b = 0; b < KEY_BYTES; b++) begin
			key_masked[KEY_BITS-1-8*b -: 8] =
				(LEN_W'(b) < len_sat) ? in_chars[KEY_BITS-1-8*b -: 8] : 8'h00;
		end
	end

	// Select the write source: a new key or the winner of the compare
	always_comb begin
		wr_en   = cmd.load_wr || cmd.merge_wr;
		wr_bank = cmd.load_wr ? 1'b0 : cmd.dst_bank;
		if (cmd.load_wr) begin
			wr_data = {len_sat, key_masked};
		end else begin
			wr_data = cmd.take_j ? rd_b_q : rd_a_q;
		end
	end

	// Write port: two banks share one array, bank bit on top
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[{wr_bank, cmd.wr_addr}] <= wr_data;
		end
	end

	// Two registered read ports from the source bank
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_a_q <= mem_q[{cmd.src_bank, cmd.rd_addr_a}];
			rd_b_q <= mem_q[{cmd.src_bank, cmd.rd_addr_b}];
		end
	end

	// Order by length, then by bytes as one unsigned word
	assign len_a = rd_a_q[ENTRY_W-1 -: LEN_W];
	assign len_b = rd_b_q[ENTRY_W-1 -: LEN_W];
	assign stat.after = (len_a != len_b) ? (len_a > len_b)
		: (rd_a_q[KEY_BITS-1:0] > rd_b_q[KEY_BITS-1:0]);

	assign out_chars = rd_a_q[KEY_BITS-1:0];
	assign out_len   = len_a;

endmodule

[rtl/skms_ctrl.sv]
// Sequencer for loading, bottom-up merge passes and draining of the key store.
`include "string_key_merge_sorter_macros.svh"
module skms_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_valid,
	input  logic               s_last,
	output logic               s_ready,
	output logic               m_valid,
	input  logic               m_ready,
	output logic               m_last,
	output logic               m_drop,
	input  skms_pkg::dp_stat_t stat,
	output skms_pkg::dp_cmd_t  cmd
);
	import skms_pkg::*;

	state_t state_q, state_d;
	cnt_t   count_q;
	logic   ovf_q;
	cnt_t   n_q;
	cnt_t   w_q;
	lo_t    lo_q;
	cnt_t   i_q, j_q, k_q, mid_q, hi_q;
	logic   src_q;
	cnt_t   o_q;

	logic   s_fire, m_fire, store_ok, take_j, k_last;
	logic   sort_done, pass_done;
	lo_t    n_ext, mid_raw, hi_raw, lo_adv;
	cnt_t   mid_c, hi_c;

	// Handshakes and loop bounds
	always_comb begin
		s_fire    = s_valid && s_ready;
		m_fire    = m_valid && m_ready;
		store_ok  = count_q < CNT_W'(MAX_KEYS);
		n_ext     = LO_W'(n_q);
		mid_raw   = lo_q + LO_W'(w_q);
		hi_raw    = lo_q + (LO_W'(w_q) << 1);
		mid_c     = (mid_raw > n_ext) ? n_q : mid_raw[CNT_W-1:0];
		hi_c      = (hi_raw > n_ext) ? n_q : hi_raw[CNT_W-1:0];
		lo_adv    = lo_q + (LO_W'(w_q) << 1);
		sort_done = w_q >= n_q;
		pass_done = lo_q >= n_ext;
		take_j    = (i_q >= mid_q) || ((j_q < hi_q) && stat.after);
		k_last    = CNT_W'(k_q + 1'b1) == hi_q;
		m_last    = CNT_W'(o_q + 1'b1) == n_q;
		m_drop    = ovf_q;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d       = state_q;
		s_ready       = 1'b0;
		m_valid       = 1'b0;
		cmd           = '0;
		cmd.src_bank  = src_q;
		cmd.dst_bank  = ~src_q;
		cmd.take_j    = take_j;
		cmd.rd_addr_a = i_q[IDX_W-1:0];
		cmd.rd_addr_b = j_q[IDX_W-1:0];
		cmd.wr_addr   = k_q[IDX_W-1:0];
		unique case (state_q)
			ST_LOAD: begin
				s_ready       = 1'b1;
				cmd.load_wr   = s_fire && store_ok;
				cmd.wr_addr   = count_q[IDX_W-1:0];
				if (s_fire && s_last) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (sort_done) begin
					state_d = ST_ORD;
				end else if (!pass_done) begin
					state_d = ST_MRD;
				end
			end
			ST_MRD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_MWR;
			end
			ST_MWR: begin
				cmd.merge_wr = 1'b1;
				state_d      = k_last ? ST_RUN : ST_MRD;
			end
			ST_ORD: begin
				cmd.rd_en     = 1'b1;
				cmd.rd_addr_a = o_q[IDX_W-1:0];
				state_d       = ST_OWAIT;
			end
			ST_OWAIT: begin
				m_valid = 1'b1;
				if (m_fire) begin
					state_d = m_last ? ST_LOAD : ST_ORD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// Counters for the batch, the merge passes and the drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			n_q     <= '0;
			w_q     <= '0;
			lo_q    <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
			src_q   <= 1'b0;
			o_q     <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (s_fire) begin
						if (store_ok) begin
							count_q <= count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_last) begin
							n_q   <= store_ok ? CNT_W'(count_q + 1'b1) : count_q;
							w_q   <= CNT_W'(1);
							lo_q  <= '0;
							src_q <= 1'b0;
						end
					end
				end
				ST_RUN: begin
					if (sort_done) begin
						o_q <= '0;
					end else if (pass_done) begin
						w_q   <= w_q << 1;
						lo_q  <= '0;
						src_q <= ~src_q;
					end else begin
						i_q   <= lo_q[CNT_W-1:0];
						j_q   <= mid_c;
						k_q   <= lo_q[CNT_W-1:0];
						mid_q <= mid_c;
						hi_q  <= hi_c;
					end
				end
				ST_MWR: begin
					if (take_j) begin
						j_q <= j_q + 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
					end
					k_q <= k_q + 1'b1;
					if (k_last) begin
						lo_q <= lo_adv;
					end
				end
				ST_OWAIT: begin
					if (m_fire) begin
						if (m_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
						end else begin
							o_q <= o_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// A merge step always has a slot left in its run
	`SKMS_ASSERT_IMP(a_merge_in_run, clk, arst_n, state_q == ST_MWR, k_q < hi_q)
	// A merge step always has a key left in one of the two runs
	`SKMS_ASSERT_IMP(a_merge_has_key, clk, arst_n, state_q == ST_MWR,
		(i_q < mid_q) || (j_q < hi_q))
	// A request into a full store flags the batch
	`SKMS_ASSERT_NXT(a_full_flags, clk, arst_n, s_fire && !store_ok, ovf_q)
	// The final result clears the batch and reopens the input
	`SKMS_ASSERT_NXT(a_batch_clear, clk, arst_n, m_fire && m_last,
		(state_q == ST_LOAD) && (count_q == '0) && !ovf_q)

endmodule

[rtl/string_key_merge_sorter.sv]
// Top level of the string key merge sorter: stream ports, controller and datapath.
//
// Input stream (s_axis): one key per request, tdata carries the key bytes
// (first character in the top byte) and the length; tlast closes a batch.
// Keys are taken at one per cycle while loading. Lengths above eight are
// treated as eight, bytes past the length are cleared. Up to 64 keys are
// kept; later keys of the batch are discarded and flagged on tuser.
// After tlast the input is held off while a stable bottom-up merge sort runs
// over a two-bank key memory, ordering by length and then byte by byte, in
// ceil(log2 n) passes for n keys. Each merged key is read from the single
// memory and then written back. Output stream (m_axis): keys in ascending
// order, each read from memory and then presented before the next is read,
// tlast on the final key and tuser set on every key of a batch that dropped
// keys. While the receiver stalls, the block holds the current result and
// waits. The next batch is accepted after the final result is taken. Reset
// (arst_n low) empties the batch and returns the block to loading; memory is
// not cleared.
module string_key_merge_sorter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// key_chars [63:0], key_length [67:64], zero pad above
	input  logic [skms_pkg::TDATA_W-1:0]  s_axis_tdata,
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// sorted_chars [63:0], sorted_length [67:64], zero pad above
	output logic [skms_pkg::TDATA_W-1:0]  m_axis_tdata,
	output logic                          m_axis_tlast,
	// dropped [0]
	output logic                          m_axis_tuser
);
	import skms_pkg::*;

	dp_cmd_t             cmd;
	dp_stat_t            stat;
	logic [KEY_BITS-1:0] out_chars;
	logic [LEN_W-1:0]    out_len;

	// Sequence the batch
	skms_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_last  (s_axis_tlast),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_last  (m_axis_tlast),
		.m_drop  (m_axis_tuser),
		.stat    (stat),
		.cmd     (cmd)
	);

	// Store, compare and read keys
	skms_datapath u_datapath (
		.clk       (clk),
		.in_chars  (s_axis_tdata[KEY_BITS-1:0]),
		.in_len    (s_axis_tdata[ENTRY_W-1:KEY_BITS]),
		.cmd       (cmd),
		.stat      (stat),
		.out_chars (out_chars),
		.out_len   (out_len)
	);

	// Pack the result
	assign m_axis_tdata = TDATA_W'({out_len, out_chars});

endmodule
